// File: sv/midi_file_chunk_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef MIDI_FILE_CHUNK_DEFRAMER_TOP_MACROS_SVH
`define MIDI_FILE_CHUNK_DEFRAMER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MFCD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define MFCD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define MFCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mfcd_pkg.sv
// Types and constants of the MIDI file chunk deframer.
package mfcd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int HDR_BYTES  = 14;
    localparam int MIN_BYTES  = 18;
    localparam int POS_W      = 5;
    localparam int TDATA_W    = 152;

    localparam logic [4:0] POS_TAG0_END = 5'd3;
    localparam logic [4:0] POS_HDR_END  = 5'd13;
    localparam logic [4:0] POS_TAG1_END = 5'd17;
    localparam logic [4:0] POS_SAT      = 5'd18;

    localparam logic [31:0] TAG_HEADER = 32'h4D546864;  // "MThd"
    localparam logic [31:0] TAG_TRACK  = 32'h4D54726B;  // "MTrk"
    localparam logic [23:0] TAIL_END   = 24'hFF2F00;
    localparam logic [15:0] TRK_MAX    = 16'hFFFF;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_HEADER  = 2'd0;
    localparam kind_t KIND_TRACK   = 2'd1;
    localparam kind_t KIND_SUMMARY = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SCAN   = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [15:0] tracks_found;
        logic        file_valid;
        logic [31:0] track_length;
        logic [15:0] track_index;
        logic        timecode_mode;
        logic [15:0] division_word;
        logic [15:0] declared_tracks;
        logic [15:0] file_format;
        logic [31:0] header_length;
        logic        last_of_run;
        kind_t       event_kind;
    } result_t;

    // Up to two results per byte; first slot goes out first.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

// File: sv/mfcd_parser.sv
// Byte parser: header capture, tag scan, length read, body skip, summary.
module mfcd_parser
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [7:0]     file_byte,
    input  logic           final_byte,
    output mfcd_pkg::push_t push
);
    import mfcd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  hdr_reg [HDR_BYTES];
    logic [23:0] tag_reg, tag_next;
    logic [1:0]  fill_reg, fill_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  lcnt_reg, lcnt_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] trk_reg, trk_next;
    logic [1:0]  tags_ok_reg, tags_ok_next;
    logic [23:0] tail_reg, tail_next;

    logic [31:0] tag_word;
    logic [31:0] skip_dec;
    logic [15:0] div_word;
    logic [4:0]  pos_inc;
    logic        main_v;
    result_t     main_r;
    result_t     sum_r;

    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        fill_next    = fill_reg;
        acc_next     = acc_reg;
        lcnt_next    = lcnt_reg;
        skip_next    = skip_reg;
        trk_next     = trk_reg;
        tags_ok_next = tags_ok_reg;
        tail_next    = {tail_reg[15:0], file_byte};
        tag_word     = {tag_reg, file_byte};
        skip_dec     = skip_reg - 32'd1;
        div_word     = {hdr_reg[12], file_byte};
        main_v       = 1'b0;
        main_r       = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == POS_TAG0_END &&
                    {hdr_reg[0], hdr_reg[1], hdr_reg[2], file_byte} == TAG_HEADER)
                begin
                    tags_ok_next[0] = 1'b1;
                end
                if (pos_reg >= POS_HDR_END)
                begin
                    main_v                 = 1'b1;
                    main_r.event_kind      = KIND_HEADER;
                    main_r.header_length   = {hdr_reg[4], hdr_reg[5], hdr_reg[6], hdr_reg[7]};
                    main_r.file_format     = {hdr_reg[8], hdr_reg[9]};
                    main_r.declared_tracks = {hdr_reg[10], hdr_reg[11]};
                    main_r.division_word   = div_word;
                    main_r.timecode_mode   = div_word[15];
                    phase_next = PH_SCAN;
                    tag_next   = '0;
                    fill_next  = '0;
                end
            end
            PH_SCAN:
            begin
                if (fill_reg == 2'd3 && tag_word == TAG_TRACK)
                begin
                    if (pos_reg == POS_TAG1_END)
                    begin
                        tags_ok_next[1] = 1'b1;
                    end
                    phase_next = PH_LENGTH;
                    acc_next   = '0;
                    lcnt_next  = '0;
                    tag_next   = '0;
                    fill_next  = '0;
                end
                else
                begin
                    tag_next = tag_word[23:0];
                    if (fill_reg != 2'd3)
                    begin
                        fill_next = fill_reg + 2'd1;
                    end
                end
            end
            PH_LENGTH:
            begin
                acc_next = {acc_reg[23:0], file_byte};
                if (lcnt_reg == 2'd3)
                begin
                    main_v              = 1'b1;
                    main_r.event_kind   = KIND_TRACK;
                    main_r.track_index  = trk_reg;
                    main_r.track_length = acc_next;
                    if (trk_reg != TRK_MAX)
                    begin
                        trk_next = trk_reg + 16'd1;
                    end
                    skip_next  = acc_next;
                    phase_next = (acc_next != '0) ? PH_SKIP : PH_SCAN;
                    lcnt_next  = '0;
                    tag_next   = '0;
                    fill_next  = '0;
                end
                else
                begin
                    lcnt_next = lcnt_reg + 2'd1;
                end
            end
            PH_SKIP:
            begin
                // Skip is entered with a nonzero count, so it always decrements.
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_SCAN;
                    tag_next   = '0;
                    fill_next  = '0;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        pos_inc  = (pos_reg < POS_SAT) ? pos_reg + 5'd1 : pos_reg;
        pos_next = pos_inc;

        sum_r              = '0;
        sum_r.event_kind   = KIND_SUMMARY;
        sum_r.file_valid   = (pos_inc >= POS_SAT) && (tags_ok_next == 2'b11) &&
                             (tail_next == TAIL_END);
        sum_r.tracks_found = trk_next;
        sum_r.last_of_run  = 1'b1;
        main_r.last_of_run = !final_byte;

        push.v0 = en && (main_v || final_byte);
        push.v1 = en && main_v && final_byte;
        push.r0 = main_v ? main_r : sum_r;
        push.r1 = sum_r;

        // Drop back to the reset state after the last byte of a file.
        if (final_byte)
        begin
            phase_next   = PH_HEADER;
            pos_next     = '0;
            tag_next     = '0;
            fill_next    = '0;
            acc_next     = '0;
            lcnt_next    = '0;
            skip_next    = '0;
            trk_next     = '0;
            tags_ok_next = '0;
            tail_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            tag_reg     <= '0;
            fill_reg    <= '0;
            acc_reg     <= '0;
            lcnt_reg    <= '0;
            skip_reg    <= '0;
            trk_reg     <= '0;
            tags_ok_reg <= '0;
            tail_reg    <= '0;
        end
        else if (en)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            tag_reg     <= tag_next;
            fill_reg    <= fill_next;
            acc_reg     <= acc_next;
            lcnt_reg    <= lcnt_next;
            skip_reg    <= skip_next;
            trk_reg     <= trk_next;
            tags_ok_reg <= tags_ok_next;
            tail_reg    <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && phase_reg == PH_HEADER && pos_reg < POS_SAT && pos_reg <= POS_HDR_END)
        begin
            hdr_reg[pos_reg[3:0]] <= file_byte;
        end
    end

endmodule

// File: sv/mfcd_out_queue.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
module mfcd_out_queue #(
    parameter int DEPTH = mfcd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mfcd_pkg::push_t  push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output mfcd_pkg::result_t out_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import mfcd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   wr_p1;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];
    assign room      = (cnt_reg <= CW'(DEPTH - 2));
    assign level     = cnt_reg;
    assign wr_p1     = ptr_inc(wr_reg);

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push.v0) + CW'(push.v1) - CW'(pop);
        if (push.v1)
        begin
            wr_next = ptr_inc(wr_p1);
        end
        else if (push.v0)
        begin
            wr_next = wr_p1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_p1] <= push.r1;
        end
    end

endmodule

// File: sv/midi_file_chunk_deframer_top.sv
// Top level of the MIDI file chunk deframer.
//
//  Channel | Role    | tdata                  | tuser      | tlast
//  s_*     | bytes   | file_byte              | -          | final_byte
//  m_*     | results | header..tracks_found   | event_kind | last_of_run
//
// One byte per cycle while the queue has room: each byte sits in the input register, where
// the parser updates its state and posts its results in the same cycle.
// A final byte that also ends the header or a track length posts two results,
// which drain over two output transfers through a QUEUE_DEPTH-entry queue.
// Input stalls only while the queue has fewer than two free entries.
// Reset is asynchronous; no clearing pass follows it.
module midi_file_chunk_deframer_top #(
    parameter int QUEUE_DEPTH = mfcd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] file_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] header_length, [47:32] file_format, [63:48] declared_tracks,
    // [79:64] division_word, [80] timecode_mode, [96:81] track_index,
    // [128:97] track_length, [129] file_valid, [145:130] tracks_found, zero pad
    output logic [mfcd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] event_kind
    output logic         m_tlast
);
    import mfcd_pkg::*;
    `include "midi_file_chunk_deframer_top_macros.svh"

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_fin_reg;
    logic        room;
    logic        proc;
    push_t       push;
    result_t     res;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

    assign proc     = in_vld_reg && room;
    assign s_tready = !in_vld_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    mfcd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (proc),
        .file_byte  (in_byte_reg),
        .final_byte (in_fin_reg),
        .push       (push)
    );

    mfcd_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res),
        .level     (level)
    );

    assign m_tuser = res.event_kind;
    assign m_tlast = res.last_of_run;
    assign m_tdata = {6'd0, res.tracks_found, res.file_valid, res.track_length,
                      res.track_index, res.timecode_mode, res.division_word,
                      res.declared_tracks, res.file_format, res.header_length};

    `MFCD_ASSERT_ALWAYS(a_level_bound, level <= QUEUE_DEPTH, "result queue overflow")
    `MFCD_ASSERT_IMPLY(a_kind_legal, m_tvalid,
        m_tuser == KIND_HEADER || m_tuser == KIND_TRACK || m_tuser == KIND_SUMMARY,
        "illegal event kind on output")
    `MFCD_ASSERT_IMPLY(a_pair_ends_summary, push.v1,
        push.v0 && push.r1.event_kind == KIND_SUMMARY && !push.r0.last_of_run,
        "second result of a byte must be the summary")
    `MFCD_ASSERT_NEXT(a_stall_holds, in_vld_reg && !room, in_vld_reg,
        "stalled input byte lost")

endmodule
